### hw/rtl/per_user_sliding_window_policer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window policer
// Shared concurrent assertion forms; clock clk, disabled in reset rst.
// ----------------------------------------------------------------------------
`ifndef PER_USER_SLIDING_WINDOW_POLICER_CORE_ASSERT_SVH
`define PER_USER_SLIDING_WINDOW_POLICER_CORE_ASSERT_SVH

// Same-cycle implication
`define PSWP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("policer assertion failed");

// Next-cycle implication
`define PSWP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("policer assertion failed");

`endif

### hw/rtl/pswp_pkg.sv
// ----------------------------------------------------------------------------
// pswp_pkg
// Item types, verdict codes and register indexes of the policer.
// ----------------------------------------------------------------------------
package pswp_pkg;

  typedef struct packed {
    logic        action;
    logic [5:0]  user_slot;
    logic [23:0] byte_length;
    logic [31:0] client_addr;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [1:0] verdict;
    logic       kick;
  } out_item_t;

  localparam logic [1:0] VERDICT_ACCEPT      = 2'd0;
  localparam logic [1:0] VERDICT_KICK_COUNT  = 2'd1;
  localparam logic [1:0] VERDICT_KICK_BYTES  = 2'd2;
  localparam logic [1:0] VERDICT_RELEASED    = 2'd3;

  localparam logic ACTION_TRANSFER = 1'b0;
  localparam logic ACTION_RELEASE  = 1'b1;

  localparam logic [2:0] REG_MAX_COMMANDS    = 3'd0;
  localparam logic [2:0] REG_MAX_KBYTES      = 3'd1;
  localparam logic [2:0] REG_POLICING_ENABLE = 3'd2;
  localparam logic [2:0] REG_TRUSTED_ADDR_A  = 3'd3;
  localparam logic [2:0] REG_TRUSTED_ADDR_B  = 3'd4;
  localparam logic [2:0] REG_TRUSTED_VALID   = 3'd5;

  localparam logic [31:0] WINDOW_SECONDS = 32'd60;
  localparam int          KBYTE_SHIFT    = 10;
  localparam logic [31:0] LOCALHOST_ADDR = 32'h7F00_0001;

endpackage

### hw/rtl/pswp_ram.sv
// ----------------------------------------------------------------------------
// pswp_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pswp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/per_user_sliding_window_policer_core.sv
// ----------------------------------------------------------------------------
// per_user_sliding_window_policer_core
// Per-user sliding-window transfer policer with a ring log per user.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request item
//   (transfer or release). Output channel out_valid/out_ready/out_data
//   returns exactly one verdict item per request, in order.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle.
// Sequence:
//   One item at a time. Release, trusted and out-of-range requests go
//   straight to the verdict. A policed transfer reads its user record,
//   then examines log entries from the oldest (each expired entry pruned
//   and the first live one) and decides; if accepted, it drops the oldest
//   entry when the ring is full and appends. Each examined entry costs one
//   read of the log memory and one check.
// Reset:
//   All users read as unknown at once (a valid bit per user); registers
//   return to defaults. No clearing pass is needed.
// Stall:
//   A verdict waits in the output register while out_ready is low; the next
//   item is still taken and worked, and its verdict holds until it frees.
// ----------------------------------------------------------------------------
`include "per_user_sliding_window_policer_core_assert.svh"

module per_user_sliding_window_policer_core #(
  parameter int USERS     = 64,
  parameter int LOG_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pswp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pswp_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int UW  = $clog2(USERS);
  localparam int HW  = $clog2(LOG_DEPTH);
  localparam int CW  = $clog2(LOG_DEPTH + 1);
  localparam int LAW = $clog2(USERS * LOG_DEPTH);
  localparam int URW = HW + CW + 32;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UREAD  = 4'd1;
  localparam logic [3:0] S_PREQ   = 4'd2;
  localparam logic [3:0] S_PCHK   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_DREQ   = 4'd5;
  localparam logic [3:0] S_DCHK   = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // Configuration registers
  logic [7:0]  max_commands;
  logic [7:0]  max_kbytes;
  logic        policing_enable;
  logic [31:0] trusted_addr_a;
  logic [31:0] trusted_addr_b;
  logic [1:0]  trusted_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_commands    <= 8'd50;
      max_kbytes      <= 8'd25;
      policing_enable <= 1'b1;
      trusted_addr_a  <= pswp_pkg::LOCALHOST_ADDR;
      trusted_addr_b  <= 32'd0;
      trusted_valid   <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        pswp_pkg::REG_MAX_COMMANDS:    max_commands    <= cfg_data[7:0];
        pswp_pkg::REG_MAX_KBYTES:      max_kbytes      <= cfg_data[7:0];
        pswp_pkg::REG_POLICING_ENABLE: policing_enable <= cfg_data[0];
        pswp_pkg::REG_TRUSTED_ADDR_A:  trusted_addr_a  <= cfg_data;
        pswp_pkg::REG_TRUSTED_ADDR_B:  trusted_addr_b  <= cfg_data;
        pswp_pkg::REG_TRUSTED_VALID:   trusted_valid   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Control and working registers
  logic [3:0]     state;
  logic [UW-1:0]  slot;
  logic [LAW-1:0] base;
  logic [23:0]    len;
  logic [31:0]    now;
  logic           pres;
  logic [HW-1:0]  head;
  logic [CW-1:0]  cnt;
  logic [31:0]    sum;
  logic [1:0]     res;
  logic [USERS-1:0] uvalid;

  // Memory ports
  logic             urd_valid;
  logic [URW-1:0]   urdata;
  logic             uwe;
  logic [URW-1:0]   uwdata;
  logic             lwe;
  logic [LAW-1:0]   lwaddr;
  logic [LAW-1:0]   lraddr;
  logic [55:0]      lrdata;

  // Decode of the incoming item
  logic           in_acc;
  logic           in_range;
  logic           trusted;
  logic [UW-1:0]  in_slot;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_range = ({26'd0, in_data.user_slot} < 32'(USERS));
  assign in_slot  = UW'(in_data.user_slot);
  assign trusted  = (trusted_valid[0] && (in_data.client_addr == trusted_addr_a)) ||
                    (trusted_valid[1] && (in_data.client_addr == trusted_addr_b));

  // Arithmetic on the current user record
  logic [31:0]   age;
  logic          expired;
  logic [23:0]   old_len;
  logic [31:0]   old_time;
  logic [31:0]   sum_sub;
  logic [HW-1:0] head_inc;
  logic [17:0]   limit;
  logic [32:0]   sum_len;
  logic [32:0]   sum_add_w;
  logic [31:0]   sum_add;
  logic [HW:0]   pos_w;
  logic [HW-1:0] pos;
  logic [1:0]    verdict_calc;

  assign old_time  = lrdata[55:24];
  assign old_len   = lrdata[23:0];
  assign age       = now - old_time;
  assign expired   = (age > pswp_pkg::WINDOW_SECONDS);
  assign sum_sub   = (sum >= {8'd0, old_len}) ? (sum - {8'd0, old_len}) : 32'd0;
  assign head_inc  = (head == HW'(LOG_DEPTH - 1)) ? '0 : (head + HW'(1));
  assign limit     = {max_kbytes, 10'd0};
  assign sum_len   = {1'b0, sum} + {9'd0, len};
  assign sum_add_w = sum_len;
  assign sum_add   = sum_add_w[32] ? 32'hFFFF_FFFF : sum_add_w[31:0];
  assign pos_w     = (HW + 1)'(head) + (HW + 1)'(cnt);
  assign pos       = (pos_w >= (HW + 1)'(LOG_DEPTH)) ?
                     HW'(pos_w - (HW + 1)'(LOG_DEPTH)) : HW'(pos_w);

  always_comb begin
    verdict_calc = pswp_pkg::VERDICT_ACCEPT;
    if (policing_enable) begin
      if (pres) begin
        if (32'(cnt) >= {24'd0, max_commands}) begin
          verdict_calc = pswp_pkg::VERDICT_KICK_COUNT;
        end else if (sum_len > {15'd0, limit}) begin
          verdict_calc = pswp_pkg::VERDICT_KICK_BYTES;
        end
      end else if (len > {6'd0, limit}) begin
        verdict_calc = pswp_pkg::VERDICT_KICK_BYTES;
      end
    end
  end

  // Memory addressing and write data
  assign lraddr = base + LAW'(head);
  assign lwaddr = base + LAW'(pos);
  assign lwe    = (state == S_WRITE);
  assign uwe    = (state == S_WRITE);
  assign uwdata = {head, cnt + CW'(1), sum_add};

  pswp_ram #(.WIDTH(URW), .DEPTH(USERS)) u_user_ram (
    .clk   (clk),
    .we    (uwe),
    .waddr (slot),
    .wdata (uwdata),
    .raddr (in_slot),
    .rdata (urdata)
  );

  pswp_ram #(.WIDTH(56), .DEPTH(USERS * LOG_DEPTH)) u_log_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (lwaddr),
    .wdata ({now, len}),
    .raddr (lraddr),
    .rdata (lrdata)
  );

  // Sequencer: read user, prune, decide, append, hand off
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      uvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the handed-off verdict unless a new one is loaded below
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            slot      <= in_slot;
            base      <= LAW'(in_slot) * LAW'(LOG_DEPTH);
            len       <= in_data.byte_length;
            now       <= in_data.now_seconds;
            urd_valid <= uvalid[in_slot];
            if (in_data.action == pswp_pkg::ACTION_RELEASE) begin
              if (in_range) begin
                uvalid[in_slot] <= 1'b0;
              end
              res   <= pswp_pkg::VERDICT_RELEASED;
              state <= S_DONE;
            end else if (!in_range || trusted) begin
              res   <= pswp_pkg::VERDICT_ACCEPT;
              state <= S_DONE;
            end else begin
              state <= S_UREAD;
            end
          end
        end
        S_UREAD: begin
          pres <= urd_valid;
          if (urd_valid) begin
            head <= urdata[URW-1 -: HW];
            cnt  <= urdata[CW+31:32];
            sum  <= urdata[31:0];
          end else begin
            head <= '0;
            cnt  <= '0;
            sum  <= '0;
          end
          state <= (urd_valid && (urdata[CW+31:32] != '0)) ? S_PREQ : S_DECIDE;
        end
        S_PREQ: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (expired) begin
            sum   <= sum_sub;
            head  <= head_inc;
            cnt   <= cnt - CW'(1);
            state <= (cnt == CW'(1)) ? S_DECIDE : S_PREQ;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res <= verdict_calc;
          if (verdict_calc != pswp_pkg::VERDICT_ACCEPT) begin
            state <= S_DONE;
          end else if (cnt == CW'(LOG_DEPTH)) begin
            state <= S_DREQ;
          end else begin
            state <= S_WRITE;
          end
        end
        S_DREQ: begin
          state <= S_DCHK;
        end
        S_DCHK: begin
          sum   <= sum_sub;
          head  <= head_inc;
          cnt   <= cnt - CW'(1);
          state <= S_WRITE;
        end
        S_WRITE: begin
          uvalid[slot] <= 1'b1;
          state        <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            out_data.verdict <= res;
            out_data.kick    <= (res == pswp_pkg::VERDICT_KICK_COUNT) ||
                                (res == pswp_pkg::VERDICT_KICK_BYTES);
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks; kick is set exactly for the two kick codes, whose bits differ
  `PSWP_ASSERT_NEXT(a_accept_starts_work, in_acc, state != S_IDLE)
  `PSWP_ASSERT_IMPLY(a_count_bounded, state > S_UREAD && state < S_DONE, cnt <= CW'(LOG_DEPTH))
  `PSWP_ASSERT_IMPLY(a_kick_matches, out_valid, out_data.kick == (^out_data.verdict))

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window policer testbench
// Drives random and directed transfer and release items through the policer,
// predicts each verdict with a per-user log of its own and compares in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_USERS = 64;
  localparam int RING = 256;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  pswp_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  pswp_pkg::out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  per_user_sliding_window_policer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow configuration
  logic [7:0] lim_cmds;
  logic [7:0] lim_kb;
  logic police_on;
  logic [31:0] trust_a;
  logic [31:0] trust_b;
  logic [1:0] trust_en;

  // Shadow per-user log
  logic [31:0] ring_time [NUM_USERS][RING];
  logic [23:0] ring_len [NUM_USERS][RING];
  int unsigned ring_head [NUM_USERS];
  int unsigned ring_cnt [NUM_USERS];
  logic [31:0] user_bytes [NUM_USERS];
  bit known [NUM_USERS];

  pswp_pkg::in_item_t pending_items[$];
  pswp_pkg::out_item_t verdicts_due[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [31:0] clock_now = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Append one item to the pending queue
  function automatic void enqueue(input pswp_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void drop_oldest(input int u);
    logic [23:0] l;
    l = ring_len[u][ring_head[u]];
    user_bytes[u] = (user_bytes[u] >= l) ? user_bytes[u] - l : 32'd0;
    ring_head[u] = (ring_head[u] + 1) % RING;
    ring_cnt[u]--;
  endfunction

  function automatic void forget_user(input int u);
    ring_head[u] = 0;
    ring_cnt[u] = 0;
    user_bytes[u] = 0;
    known[u] = 0;
  endfunction

  // Predict the verdict of one item and update the shadow log
  function automatic pswp_pkg::out_item_t police(input pswp_pkg::in_item_t it);
    pswp_pkg::out_item_t r;
    int u;
    logic [1:0] v;
    logic [32:0] sum;
    logic [32:0] lim;
    int unsigned pos;
    u = it.user_slot;
    v = pswp_pkg::VERDICT_ACCEPT;
    lim = {25'd0, lim_kb} << pswp_pkg::KBYTE_SHIFT;
    if (it.action == pswp_pkg::ACTION_RELEASE) begin
      forget_user(u);
      r.verdict = pswp_pkg::VERDICT_RELEASED;
      r.kick = 1'b0;
      return r;
    end
    if ((trust_en[0] && it.client_addr == trust_a) ||
        (trust_en[1] && it.client_addr == trust_b)) begin
      r.verdict = pswp_pkg::VERDICT_ACCEPT;
      r.kick = 1'b0;
      return r;
    end
    if (known[u]) begin
      while (ring_cnt[u] > 0 &&
             32'(it.now_seconds - ring_time[u][ring_head[u]]) > pswp_pkg::WINDOW_SECONDS)
        drop_oldest(u);
      sum = {1'b0, user_bytes[u]} + {9'd0, it.byte_length};
      if (police_on && ring_cnt[u] >= lim_cmds) v = pswp_pkg::VERDICT_KICK_COUNT;
      else if (police_on && sum > lim) v = pswp_pkg::VERDICT_KICK_BYTES;
    end else if (police_on && {9'd0, it.byte_length} > lim) begin
      v = pswp_pkg::VERDICT_KICK_BYTES;
    end
    if (v == pswp_pkg::VERDICT_ACCEPT) begin
      if (ring_cnt[u] >= RING) drop_oldest(u);
      pos = (ring_head[u] + ring_cnt[u]) % RING;
      ring_time[u][pos] = it.now_seconds;
      ring_len[u][pos] = it.byte_length;
      ring_cnt[u]++;
      sum = {1'b0, user_bytes[u]} + {9'd0, it.byte_length};
      user_bytes[u] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      known[u] = 1;
    end
    r.verdict = v;
    r.kick = (v != pswp_pkg::VERDICT_ACCEPT);
    return r;
  endfunction

  // Driver: present the next item, hold until accepted
  always @(posedge clk) begin
    pswp_pkg::in_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_data <= nxt;
        verdicts_due = {verdicts_due, police(nxt)};
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: compare each verdict with the oldest expectation
  always @(posedge clk) begin
    pswp_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        report($sformatf("unexpected verdict %0d", out_data.verdict));
      end else begin
        e = verdicts_due.pop_front();
        if (out_data.verdict !== e.verdict)
          report($sformatf("verdict %0d, want %0d", out_data.verdict, e.verdict));
        if (out_data.kick !== e.kick)
          report($sformatf("kick %0b, want %0b", out_data.kick, e.kick));
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pswp_pkg::REG_MAX_COMMANDS:    lim_cmds = val[7:0];
      pswp_pkg::REG_MAX_KBYTES:      lim_kb = val[7:0];
      pswp_pkg::REG_POLICING_ENABLE: police_on = val[0];
      pswp_pkg::REG_TRUSTED_ADDR_A:  trust_a = val;
      pswp_pkg::REG_TRUSTED_ADDR_B:  trust_b = val;
      pswp_pkg::REG_TRUSTED_VALID:   trust_en = val[1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued item has been answered
  task automatic drain();
    while (pending_items.size() > 0 || verdicts_due.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic pswp_pkg::in_item_t make_item(input logic act, input logic [5:0] u,
                                                   input logic [23:0] len,
                                                   input logic [31:0] addr);
    pswp_pkg::in_item_t it;
    it.action = act;
    it.user_slot = u;
    it.byte_length = len;
    it.client_addr = addr;
    it.now_seconds = clock_now;
    return it;
  endfunction

  // Random item: mostly transfers on a few users with small lengths
  function automatic pswp_pkg::in_item_t rand_item();
    pswp_pkg::in_item_t it;
    int r;
    logic [31:0] addr;
    r = $urandom_range(99);
    if (r < 3) clock_now = clock_now - $urandom_range(100);
    else if (r < 50) clock_now = clock_now + $urandom_range(3);
    else if (r < 53) clock_now = $urandom;
    r = $urandom_range(99);
    addr = (r < 5) ? trust_a : (r < 10) ? trust_b : $urandom;
    r = $urandom_range(99);
    it = make_item($urandom_range(99) < 4 ? pswp_pkg::ACTION_RELEASE
                                          : pswp_pkg::ACTION_TRANSFER,
                   $urandom_range(99) < 80 ? 6'($urandom_range(3)) : 6'($urandom),
                   r < 85 ? 24'($urandom_range(3000)) : 24'($urandom), addr);
    return it;
  endfunction

  initial begin
    int phase;
    rst = 1;
    cfg_we = 0;
    cfg_index = pswp_pkg::REG_MAX_COMMANDS;
    cfg_data = 0;
    lim_cmds = 50; lim_kb = 25; police_on = 1;
    trust_a = pswp_pkg::LOCALHOST_ADDR; trust_b = 0; trust_en = 1;
    for (int u = 0; u < NUM_USERS; u++) forget_user(u);
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: extremes, trusted, release, expiry, backwards time
    clock_now = 32'hFFFF_FFF0;
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd0, 24'hFFFFFF, 32'h1));
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd0, 24'd25600, 32'h1));
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd0, 24'd1, 32'h1));
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd63, 24'hFFFFFF,
                      pswp_pkg::LOCALHOST_ADDR));
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd63, 24'd0, 32'hFFFF_FFFF));
    clock_now = 32'd50;
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd0, 24'd100, 32'h2));
    clock_now = 32'd10;
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd0, 24'd100, 32'h2));
    enqueue(make_item(pswp_pkg::ACTION_RELEASE, 6'd0, 24'd0, 32'd0));
    enqueue(make_item(pswp_pkg::ACTION_RELEASE, 6'd63, 24'hFFFFFF, 32'hFFFF_FFFF));
    for (int i = 0; i < 16; i++)
      enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd1, 24'd10, 32'h3));
    drain();

    write_reg(pswp_pkg::REG_MAX_COMMANDS, 32'd0);
    write_reg(pswp_pkg::REG_TRUSTED_ADDR_B, 32'hFFFF_FFFF);
    write_reg(pswp_pkg::REG_TRUSTED_VALID, 32'd3);
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd1, 24'd1, 32'h3));
    enqueue(make_item(pswp_pkg::ACTION_TRANSFER, 6'd1, 24'd1, 32'hFFFF_FFFF));
    drain();

    // Random phases over settings and idling mixes
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_reg(pswp_pkg::REG_MAX_COMMANDS,
                phase == 3 ? 255 : phase == 5 ? 15 : $urandom_range(15, 150));
      write_reg(pswp_pkg::REG_MAX_KBYTES,
                phase == 2 ? 255 : phase == 4 ? 5 : $urandom_range(5, 150));
      write_reg(pswp_pkg::REG_POLICING_ENABLE, 32'(phase != 6));
      write_reg(pswp_pkg::REG_TRUSTED_ADDR_A, phase == 1 ? 32'h0 : $urandom);
      write_reg(pswp_pkg::REG_TRUSTED_ADDR_B, $urandom);
      write_reg(pswp_pkg::REG_TRUSTED_VALID, $urandom_range(3));
      for (int i = 0; i < 250; i++) enqueue(rand_item());
      drain();
    end

    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end
endmodule
